// ===== rtl/core/cfta_pkg.sv =====
`timescale 1ns / 1ps
// Package for the correlation filter train and apply core.
// Holds the command codes, the divider pipeline record and the saturation helpers.
// No dependencies.
package cfta_pkg;

	typedef enum logic {
		CMD_APPLY = 1'b0,
		CMD_TRAIN = 1'b1
	} cmd_t;

	localparam int DIV_STEPS = 33;
	localparam logic [15:0] RATE_RESET = 16'd8192;

	typedef struct packed {
		logic               valid;
		cmd_t               cmd;
		logic               ready;
		logic               zdiv;
		logic               sat;
		logic               neg_re;
		logic               neg_im;
		logic               ovf_re;
		logic               ovf_im;
		logic [47:0]        den;
		logic [47:0]        rem_re;
		logic [47:0]        rem_im;
		logic [32:0]        dlo_re;
		logic [32:0]        dlo_im;
		logic [32:0]        q_re;
		logic [32:0]        q_im;
		logic signed [31:0] f_re;
		logic signed [31:0] f_im;
	} div_t;

	// One restoring step on both lanes.
	function automatic div_t div_step(div_t d);
		div_t        n;
		logic [47:0] tre;
		logic [47:0] tim;
		n   = d;
		tre = {d.rem_re[46:0], d.dlo_re[32]};
		tim = {d.rem_im[46:0], d.dlo_im[32]};
		n.dlo_re = {d.dlo_re[31:0], 1'b0};
		n.dlo_im = {d.dlo_im[31:0], 1'b0};
		if (tre >= d.den) begin
			n.rem_re = tre - d.den;
			n.q_re   = {d.q_re[31:0], 1'b1};
		end else begin
			n.rem_re = tre;
			n.q_re   = {d.q_re[31:0], 1'b0};
		end
		if (tim >= d.den) begin
			n.rem_im = tim - d.den;
			n.q_im   = {d.q_im[31:0], 1'b1};
		end else begin
			n.rem_im = tim;
			n.q_im   = {d.q_im[31:0], 1'b0};
		end
		return n;
	endfunction

	// Clip to 48 bits; returns {clipped, value}.
	function automatic logic [48:0] clip48(logic signed [48:0] x);
		logic [48:0] r;
		if (x > 49'sh0_7FFF_FFFF_FFFF) begin
			r = {1'b1, 48'h7FFF_FFFF_FFFF};
		end else if (x < -49'sh0_8000_0000_0000) begin
			r = {1'b1, 48'h8000_0000_0000};
		end else begin
			r = {1'b0, x[47:0]};
		end
		return r;
	endfunction

	// Clip to 32 bits; returns {clipped, value}.
	function automatic logic [32:0] clip32(logic signed [48:0] x);
		logic [32:0] r;
		if (x > 49'sh7FFF_FFFF) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (x < -49'sh8000_0000) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, x[31:0]};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/correlation_filter_train_and_apply_core.sv =====
`timescale 1ns / 1ps
// Correlation filter train and apply core: per-bin numerator, denominator and filter memories.
// Depends on cfta_pkg.
//
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------------
// item     | start / busy           | command, bin_index, last_bin, f_re, f_im, g_re, g_im
// config   | cfg_valid / cfg_ready  | cfg_data
// result   | done (one-cycle strobe)| out_re, out_im, filter_ready, zero_divide, saturated
//
// One item per cycle while busy is low.
// A 33-step pipelined divider lies between the filter update and the output.
// After reset a clearing pass writes zero to every bin while busy is high.
// Same-bin updates in flight are forwarded into the numerator/denominator read-modify-write.
// Results cannot be held off by the receiver.
module correlation_filter_train_and_apply_core #(
	parameter int BIN_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [9:0]         bin_index,
	input  logic               last_bin,
	input  logic signed [31:0] f_re,
	input  logic signed [31:0] f_im,
	input  logic signed [31:0] g_re,
	input  logic signed [31:0] g_im,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] out_re,
	output logic signed [31:0] out_im,
	output logic               filter_ready,
	output logic               zero_divide,
	output logic               saturated
);
	import cfta_pkg::*;

	localparam int AW = $clog2(BIN_COUNT);
	localparam longint RECIP = ((64'd1 << 24) + BIN_COUNT - 1) / BIN_COUNT;

	// ---------------- configuration and clearing
	logic [15:0]   rate_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;
	logic          trained_q;

	assign cfg_ready = 1'b1;
	assign busy      = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= RATE_RESET;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				rate_q <= cfg_data;
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(BIN_COUNT - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	// ---------------- accept: bin reduction and products
	logic          acc;
	logic [30:0]   mod_prod;
	logic [23:0]   mod_rem;
	logic [AW-1:0] in_addr;

	assign acc      = start && !busy;
	assign mod_prod = 31'(bin_index) * 31'(RECIP);
	assign mod_rem  = 24'(bin_index) - 24'(mod_prod[30:24]) * 24'(BIN_COUNT);
	assign in_addr  = mod_rem[AW-1:0];

	logic                v_s1, last_s1;
	cmd_t                cmd_s1;
	logic [AW-1:0]       bin_s1;
	logic signed [31:0]  fre_s1, fim_s1;
	logic signed [63:0]  p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, p_fr2_s1, p_fi2_s1;
	logic [143:0]        ab_rd_s1;

	// ---------------- numerator/denominator memory
	logic [143:0]  ab_mem [BIN_COUNT];
	logic          ab_we;
	logic [AW-1:0] ab_wa;
	logic [143:0]  ab_wd;

	always_ff @(posedge clk) begin
		if (ab_we) begin
			ab_mem[ab_wa] <= ab_wd;
		end
		ab_rd_s1 <= ab_mem[in_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1   <= cmd_t'(command);
		last_s1  <= last_bin;
		bin_s1   <= in_addr;
		fre_s1   <= f_re;
		fim_s1   <= f_im;
		p_rr_s1  <= g_re * f_re;
		p_ii_s1  <= g_im * f_im;
		p_ir_s1  <= g_im * f_re;
		p_ri_s1  <= g_re * f_im;
		p_fr2_s1 <= f_re * f_re;
		p_fi2_s1 <= f_im * f_im;
	end

	// ---------------- stage 1: new products summed and clipped
	logic [48:0] c_pre, c_pim, c_pb;

	always_comb begin
		c_pre = clip48(49'($signed(p_rr_s1[63:16])) + 49'($signed(p_ii_s1[63:16])));
		c_pim = clip48(49'($signed(p_ir_s1[63:16])) - 49'($signed(p_ri_s1[63:16])));
		c_pb  = clip48(49'($signed(p_fr2_s1[63:16])) + 49'($signed(p_fi2_s1[63:16])));
	end

	logic                v_s2, last_s2, sat_s2;
	cmd_t                cmd_s2;
	logic [AW-1:0]       bin_s2;
	logic signed [31:0]  fre_s2, fim_s2;
	logic signed [47:0]  pre_s2, pim_s2, pb_s2;
	logic [143:0]        old_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2  <= cmd_s1;
		last_s2 <= last_s1;
		bin_s2  <= bin_s1;
		fre_s2  <= fre_s1;
		fim_s2  <= fim_s1;
		pre_s2  <= c_pre[47:0];
		pim_s2  <= c_pim[47:0];
		pb_s2   <= c_pb[47:0];
		sat_s2  <= c_pre[48] | c_pim[48] | c_pb[48];
		old_s2  <= ab_rd_s1;
	end

	// ---------------- stage 2: forward, blend, write back
	logic                v_s3, sat_s3, ready_s3;
	cmd_t                cmd_s3;
	logic [AW-1:0]       bin_s3;
	logic signed [31:0]  fre_s3, fim_s3;
	logic signed [47:0]  are_s3, aim_s3, b_s3;

	logic                wr2_v_q;
	logic [AW-1:0]       wr2_bin_q;
	logic [143:0]        wr2_d_q;

	logic [143:0]        old_sel;
	logic [16:0]         w_new, w_old;
	logic signed [65:0]  bl_re, bl_im, bl_b;
	logic signed [47:0]  are_n, aim_n, b_n;
	logic                train_s2, ready_n;

	function automatic logic signed [65:0] blend(logic signed [47:0] o, logic signed [47:0] n,
		logic [16:0] wo, logic [16:0] wn);
		logic signed [65:0] oe, ne, woe, wne;
		oe  = o;
		ne  = n;
		woe = {49'b0, wo};
		wne = {49'b0, wn};
		return oe * woe + ne * wne;
	endfunction

	always_comb begin
		train_s2 = v_s2 && (cmd_s2 == CMD_TRAIN);
		if (v_s3 && (cmd_s3 == CMD_TRAIN) && (bin_s3 == bin_s2)) begin
			old_sel = {are_s3, aim_s3, b_s3};
		end else if (wr2_v_q && (wr2_bin_q == bin_s2)) begin
			old_sel = wr2_d_q;
		end else begin
			old_sel = old_s2;
		end
		w_new = {1'b0, rate_q};
		w_old = 17'h1_0000 - w_new;
		bl_re = blend($signed(old_sel[143:96]), pre_s2, w_old, w_new);
		bl_im = blend($signed(old_sel[95:48]), pim_s2, w_old, w_new);
		bl_b  = blend($signed(old_sel[47:0]), pb_s2, w_old, w_new);
		if (trained_q) begin
			are_n = bl_re[63:16];
			aim_n = bl_im[63:16];
			b_n   = bl_b[63:16];
		end else begin
			are_n = pre_s2;
			aim_n = pim_s2;
			b_n   = pb_s2;
		end
		ready_n = trained_q | (train_s2 & last_s2);
	end

	always_comb begin
		if (clr_busy_q) begin
			ab_we = 1'b1;
			ab_wa = clr_addr_q;
			ab_wd = '0;
		end else begin
			ab_we = train_s2;
			ab_wa = bin_s2;
			ab_wd = {are_n, aim_n, b_n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3      <= 1'b0;
			wr2_v_q   <= 1'b0;
			trained_q <= 1'b0;
		end else begin
			v_s3      <= v_s2;
			wr2_v_q   <= v_s3 && (cmd_s3 == CMD_TRAIN);
			if (train_s2 && last_s2) begin
				trained_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_s3    <= cmd_s2;
		bin_s3    <= bin_s2;
		fre_s3    <= fre_s2;
		fim_s3    <= fim_s2;
		are_s3    <= are_n;
		aim_s3    <= aim_n;
		b_s3      <= b_n;
		sat_s3    <= sat_s2 & (cmd_s2 == CMD_TRAIN);
		ready_s3  <= ready_n;
		wr2_bin_q <= bin_s3;
		wr2_d_q   <= {are_s3, aim_s3, b_s3};
	end

	// ---------------- stage 3: divider setup
	div_t          prep;
	logic [47:0]   mag_re, mag_im;

	always_comb begin
		mag_re      = are_s3[47] ? 48'(-are_s3) : are_s3;
		mag_im      = aim_s3[47] ? 48'(-aim_s3) : aim_s3;
		prep        = '0;
		prep.valid  = v_s3;
		prep.cmd    = cmd_s3;
		prep.ready  = ready_s3;
		prep.zdiv   = (cmd_s3 == CMD_TRAIN) && (b_s3 <= 48'sd0);
		prep.sat    = sat_s3;
		prep.neg_re = are_s3[47];
		prep.neg_im = aim_s3[47];
		prep.den    = b_s3;
		prep.ovf_re = (mag_re >> 17) >= b_s3;
		prep.ovf_im = (mag_im >> 17) >= b_s3;
		prep.rem_re = mag_re >> 17;
		prep.rem_im = mag_im >> 17;
		prep.dlo_re = {mag_re[16:0], 16'b0};
		prep.dlo_im = {mag_im[16:0], 16'b0};
		prep.f_re   = fre_s3;
		prep.f_im   = fim_s3;
	end

	// ---------------- divider pipeline
	div_t          div_q [DIV_STEPS+1];
	logic [AW-1:0] dbin_q [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_STEPS; i++) begin
				div_q[i].valid <= 1'b0;
			end
		end else begin
			div_q[0] <= prep;
			for (int i = 1; i <= DIV_STEPS; i++) begin
				div_q[i] <= div_step(div_q[i-1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		dbin_q[0] <= bin_s3;
		for (int i = 1; i <= DIV_STEPS; i++) begin
			dbin_q[i] <= dbin_q[i-1];
		end
	end

	// ---------------- quotient finish and filter memory
	div_t               dq;
	logic signed [31:0] cre_n, cim_n;
	logic               dsat_re, dsat_im;

	always_comb begin
		dq      = div_q[DIV_STEPS];
		dsat_re = 1'b0;
		dsat_im = 1'b0;
		if (dq.neg_re) begin
			if (dq.ovf_re || (dq.q_re > 33'h0_8000_0000)) begin
				dsat_re = 1'b1;
				cre_n   = 32'sh8000_0000;
			end else begin
				cre_n   = 32'(-dq.q_re);
			end
		end else begin
			if (dq.ovf_re || (dq.q_re > 33'h0_7FFF_FFFF)) begin
				dsat_re = 1'b1;
				cre_n   = 32'sh7FFF_FFFF;
			end else begin
				cre_n   = dq.q_re[31:0];
			end
		end
		if (dq.neg_im) begin
			if (dq.ovf_im || (dq.q_im > 33'h0_8000_0000)) begin
				dsat_im = 1'b1;
				cim_n   = 32'sh8000_0000;
			end else begin
				cim_n   = 32'(-dq.q_im);
			end
		end else begin
			if (dq.ovf_im || (dq.q_im > 33'h0_7FFF_FFFF)) begin
				dsat_im = 1'b1;
				cim_n   = 32'sh7FFF_FFFF;
			end else begin
				cim_n   = dq.q_im[31:0];
			end
		end
		if (dq.zdiv) begin
			dsat_re = 1'b0;
			dsat_im = 1'b0;
			cre_n   = '0;
			cim_n   = '0;
		end
	end

	logic [63:0]   coef_mem [BIN_COUNT];
	logic          co_we;
	logic [AW-1:0] co_wa;
	logic [63:0]   co_wd;
	logic [63:0]   h_rd_s4;

	always_comb begin
		if (clr_busy_q) begin
			co_we = 1'b1;
			co_wa = clr_addr_q;
			co_wd = '0;
		end else begin
			co_we = dq.valid && (dq.cmd == CMD_TRAIN);
			co_wa = dbin_q[DIV_STEPS];
			co_wd = {cre_n, cim_n};
		end
	end

	always_ff @(posedge clk) begin
		if (co_we) begin
			coef_mem[co_wa] <= co_wd;
		end
		h_rd_s4 <= coef_mem[dbin_q[DIV_STEPS]];
	end

	logic                v_s4, ready_s4, zdiv_s4, sat_s4;
	cmd_t                cmd_s4;
	logic signed [31:0]  fre_s4, fim_s4, cre_s4, cim_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= dq.valid;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s4   <= dq.cmd;
		ready_s4 <= dq.ready;
		zdiv_s4  <= dq.zdiv;
		sat_s4   <= dq.sat | dsat_re | dsat_im;
		fre_s4   <= dq.f_re;
		fim_s4   <= dq.f_im;
		cre_s4   <= cre_n;
		cim_s4   <= cim_n;
	end

	// ---------------- apply products
	logic signed [31:0] h_re, h_im;
	logic               v_s5, ready_s5, zdiv_s5, sat_s5;
	cmd_t               cmd_s5;
	logic signed [31:0] cre_s5, cim_s5;
	logic signed [63:0] m_rr_s5, m_ii_s5, m_ri_s5, m_ir_s5;

	assign h_re = h_rd_s4[63:32];
	assign h_im = h_rd_s4[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s5   <= cmd_s4;
		ready_s5 <= ready_s4;
		zdiv_s5  <= zdiv_s4;
		sat_s5   <= sat_s4;
		cre_s5   <= cre_s4;
		cim_s5   <= cim_s4;
		m_rr_s5  <= h_re * fre_s4;
		m_ii_s5  <= h_im * fim_s4;
		m_ri_s5  <= h_re * fim_s4;
		m_ir_s5  <= h_im * fre_s4;
	end

	// ---------------- result
	logic [32:0] y_re, y_im;

	always_comb begin
		y_re = clip32(49'($signed(m_rr_s5[63:16])) - 49'($signed(m_ii_s5[63:16])));
		y_im = clip32(49'($signed(m_ri_s5[63:16])) + 49'($signed(m_ir_s5[63:16])));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		filter_ready <= ready_s5;
		if (cmd_s5 == CMD_TRAIN) begin
			out_re      <= cre_s5;
			out_im      <= cim_s5;
			zero_divide <= zdiv_s5;
			saturated   <= sat_s5;
		end else begin
			out_re      <= y_re[31:0];
			out_im      <= y_im[31:0];
			zero_divide <= 1'b0;
			saturated   <= y_re[32] | y_im[32];
		end
	end

`ifndef SYNTHESIS
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done) else $error("result during clearing pass");
	a_trained_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(trained_q)) else $error("trained flag dropped");
	a_zdiv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_divide) |-> (out_re == 32'sd0 && out_im == 32'sd0))
		else $error("zero divide result not zero");
	a_div_flow: assert property (@(posedge clk) disable iff (!arst_n)
		div_q[0].valid |-> ##(DIV_STEPS) div_q[DIV_STEPS].valid)
		else $error("divider lost an item");
`endif

endmodule

// ===== sim/correlation_filter_train_and_apply_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for correlation_filter_train_and_apply_core: random and directed
// train/apply transactions checked against an in-bench bin filter predictor.
// Depends on cfta_pkg and the core RTL.
module correlation_filter_train_and_apply_core_tb;
	import cfta_pkg::*;

	localparam int NBINS = 1024;
	localparam int LATENCY = 40;
	localparam int WATCHDOG = 200000;
	localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
	localparam longint MIN48 = -MAX48 - 1;
	localparam longint MAX32 = 64'sh7FFF_FFFF;
	localparam longint MIN32 = -MAX32 - 1;

	typedef struct {
		cmd_t             cmd;
		logic [9:0]       bin;
		logic             last;
		logic signed [31:0] fr, fi, gr, gi;
	} bin_item_t;

	typedef struct {
		logic signed [31:0] re, im;
		logic             ready, zdiv, sat;
	} bin_result_t;

	logic clk, arst_n, start, busy, command, last_bin, cfg_valid, cfg_ready, done;
	logic [9:0] bin_index;
	logic signed [31:0] f_re, f_im, g_re, g_im, out_re, out_im;
	logic [15:0] cfg_data;
	logic filter_ready, zero_divide, saturated;

	correlation_filter_train_and_apply_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.bin_index(bin_index), .last_bin(last_bin), .f_re(f_re), .f_im(f_im),
		.g_re(g_re), .g_im(g_im), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .done(done), .out_re(out_re), .out_im(out_im),
		.filter_ready(filter_ready), .zero_divide(zero_divide), .saturated(saturated)
	);

	bin_item_t   pending_items[$];
	bin_result_t expected_results[$];
	longint      numer_re_m[NBINS], numer_im_m[NBINS], denom_m[NBINS];
	longint      coef_re_m[NBINS], coef_im_m[NBINS];
	bit          trained_m;
	longint      rate_m;
	int          mismatches, idle_cycles, sender_idle_pct;
	bit          timed_out, hold_sender, item_taken;

	function automatic longint floor_q16(longint x);
		return x >>> 16;
	endfunction

	function automatic longint saturate(longint x, longint lo, longint hi, ref bit sat);
		if (x > hi) begin
			sat = 1;
			return hi;
		end
		if (x < lo) begin
			sat = 1;
			return lo;
		end
		return x;
	endfunction

	function automatic longint blend_bin(longint old, longint nw, longint r);
		longint wo, oh, ol, nh, nl;
		wo = 65536 - r;
		oh = floor_q16(old);
		ol = old - oh * 65536;
		nh = floor_q16(nw);
		nl = nw - nh * 65536;
		return wo * oh + r * nh + floor_q16(wo * ol + r * nl);
	endfunction

	function automatic longint quotient_q16(longint a, longint b, ref bit sat);
		logic [63:0] mag, q;
		mag = (a < 0) ? -a : a;
		q = (mag * 64'd65536) / b;
		if (a < 0) begin
			if (q > 64'h8000_0000) begin
				sat = 1;
				return MIN32;
			end
			return -longint'(q);
		end
		if (q > 64'h7FFF_FFFF) begin
			sat = 1;
			return MAX32;
		end
		return longint'(q);
	endfunction

	function automatic bin_result_t filter_bin(bin_item_t it);
		bin_result_t r;
		int k;
		longint fr, fi, gr, gi, pre, pim, pb, ore, oim;
		bit sat, zd;
		k = int'(it.bin);
		fr = it.fr; fi = it.fi; gr = it.gr; gi = it.gi;
		sat = 0; zd = 0;
		if (it.cmd == CMD_TRAIN) begin
			pre = saturate(floor_q16(gr * fr) + floor_q16(gi * fi), MIN48, MAX48, sat);
			pim = saturate(floor_q16(gi * fr) - floor_q16(gr * fi), MIN48, MAX48, sat);
			pb = saturate(floor_q16(fr * fr) + floor_q16(fi * fi), MIN48, MAX48, sat);
			if (trained_m) begin
				numer_re_m[k] = blend_bin(numer_re_m[k], pre, rate_m);
				numer_im_m[k] = blend_bin(numer_im_m[k], pim, rate_m);
				denom_m[k] = blend_bin(denom_m[k], pb, rate_m);
			end else begin
				numer_re_m[k] = pre;
				numer_im_m[k] = pim;
				denom_m[k] = pb;
			end
			if (denom_m[k] <= 0) begin
				zd = 1;
				coef_re_m[k] = 0;
				coef_im_m[k] = 0;
			end else begin
				coef_re_m[k] = quotient_q16(numer_re_m[k], denom_m[k], sat);
				coef_im_m[k] = quotient_q16(numer_im_m[k], denom_m[k], sat);
			end
			if (it.last)
				trained_m = 1;
			ore = coef_re_m[k];
			oim = coef_im_m[k];
		end else begin
			ore = saturate(floor_q16(coef_re_m[k] * fr) - floor_q16(coef_im_m[k] * fi),
				MIN32, MAX32, sat);
			oim = saturate(floor_q16(coef_re_m[k] * fi) + floor_q16(coef_im_m[k] * fr),
				MIN32, MAX32, sat);
		end
		r.re = ore[31:0];
		r.im = oim[31:0];
		r.ready = trained_m;
		r.zdiv = zd;
		r.sat = sat;
		return r;
	endfunction

	function automatic logic signed [31:0] rand_q16();
		case ($urandom_range(0, 5))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 0;
			3: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic bin_item_t make_item(cmd_t c, int bin, bit last);
		bin_item_t it;
		it.cmd = c;
		it.bin = 10'(bin);
		it.last = last;
		it.fr = rand_q16();
		it.fi = rand_q16();
		it.gr = rand_q16();
		it.gi = rand_q16();
		return it;
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
		end else if ((!start || item_taken) && !hold_sender && pending_items.size() > 0
				&& $urandom_range(0, 99) >= sender_idle_pct) begin
			start <= 1;
			command <= pending_items[0].cmd;
			bin_index <= pending_items[0].bin;
			last_bin <= pending_items[0].last;
			f_re <= pending_items[0].fr;
			f_im <= pending_items[0].fi;
			g_re <= pending_items[0].gr;
			g_im <= pending_items[0].gi;
			void'(pending_items.pop_front());
		end else if (item_taken) begin
			start <= 0;
		end
	end

	always @(posedge clk) begin
		bin_item_t it;
		bin_result_t e;
		item_taken <= arst_n && start && !busy;
		if (arst_n) begin
			idle_cycles++;
			if (start && !busy) begin
				it.cmd = cmd_t'(command);
				it.bin = bin_index;
				it.last = last_bin;
				it.fr = f_re; it.fi = f_im; it.gr = g_re; it.gi = g_im;
				expected_results.push_back(filter_bin(it));
				idle_cycles = 0;
			end
			if (cfg_valid && cfg_ready) begin
				rate_m = longint'(cfg_data);
				idle_cycles = 0;
			end
			if (done) begin
				idle_cycles = 0;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result re=%h im=%h", out_re, out_im);
				end else begin
					e = expected_results.pop_front();
					if (out_re !== e.re || out_im !== e.im || filter_ready !== e.ready
							|| zero_divide !== e.zdiv || saturated !== e.sat) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch exp re=%h im=%h rdy=%b zd=%b sat=%b",
								" act re=%h im=%h rdy=%b zd=%b sat=%b"},
								e.re, e.im, e.ready, e.zdiv, e.sat, out_re, out_im,
								filter_ready, zero_divide, saturated);
					end
				end
			end
			if (idle_cycles >= WATCHDOG)
				timed_out = 1;
		end
	end

	task automatic wait_drained();
		while (pending_items.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_rate(logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic queue_random(int count);
		int base, n;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				base = $urandom_range(0, 15) * 8;
				n = $urandom_range(1, 8);
				for (int j = 0; j < n; j++)
					pending_items.push_back(make_item(CMD_TRAIN, base + j, j == n - 1));
				for (int j = 0; j < n; j++)
					pending_items.push_back(make_item(CMD_APPLY, base + j,
						1'($urandom_range(0, 1))));
				i += 2 * n - 1;
			end else begin
				pending_items.push_back(make_item(cmd_t'($urandom_range(0, 1)),
					$urandom_range(0, NBINS - 1), 1'($urandom_range(0, 1))));
			end
		end
	endtask

	initial begin : stimulus
		bin_item_t it;
		arst_n = 0;
		start = 0; command = 0; bin_index = 0; last_bin = 0;
		f_re = 0; f_im = 0; g_re = 0; g_im = 0;
		cfg_valid = 0; cfg_data = RATE_RESET;
		mismatches = 0; idle_cycles = 0; timed_out = 0; hold_sender = 0;
		sender_idle_pct = 31;
		trained_m = 0; rate_m = longint'(RATE_RESET);
		for (int k = 0; k < NBINS; k++) begin
			numer_re_m[k] = 0; numer_im_m[k] = 0; denom_m[k] = 0;
			coef_re_m[k] = 0; coef_im_m[k] = 0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		pending_items.push_back(make_item(CMD_APPLY, 5, 1'b1));
		it = make_item(CMD_TRAIN, 0, 1'b0);
		it.fr = 0; it.fi = 0;
		pending_items.push_back(it);
		it = make_item(CMD_TRAIN, 1, 1'b0);
		it.fr = 32'sh7FFF_FFFF; it.fi = 32'sh8000_0000;
		it.gr = 32'sh8000_0000; it.gi = 32'sh7FFF_FFFF;
		pending_items.push_back(it);
		it = make_item(CMD_TRAIN, 1023, 1'b0);
		it.fr = 1; it.fi = 0; it.gr = 32'sh7FFF_FFFF; it.gi = 32'sh8000_0000;
		pending_items.push_back(it);
		it = make_item(CMD_TRAIN, 2, 1'b1);
		it.fr = 32'sh1_0000; it.fi = 32'sh1_0000; it.gr = 32'sh1_0000; it.gi = -32'sh1_0000;
		pending_items.push_back(it);
		for (int k = 0; k < 4; k++) begin
			pending_items.push_back(make_item(CMD_APPLY, k, 1'b1));
			pending_items.push_back(make_item(CMD_TRAIN, k, 1'b0));
		end
		it = make_item(CMD_APPLY, 1023, 1'b0);
		it.fr = 32'sh7FFF_FFFF; it.fi = 32'sh8000_0000;
		pending_items.push_back(it);
		pending_items.push_back(make_item(CMD_TRAIN, 1, 1'b0));
		pending_items.push_back(make_item(CMD_TRAIN, 1, 1'b0));
		pending_items.push_back(make_item(CMD_APPLY, 1, 1'b0));
		queue_random(380);
		wait_drained();
		hold_sender = 1;
		write_rate(16'd0);
		hold_sender = 0;
		sender_idle_pct = 59;
		queue_random(200);
		wait_drained();
		hold_sender = 1;
		write_rate(16'hFFFF);
		hold_sender = 0;
		queue_random(200);
		wait_drained();
		hold_sender = 1;
		write_rate(16'($urandom));
		hold_sender = 0;
		sender_idle_pct = 0;
		queue_random(250);
		wait_drained();
		hold_sender = 1;
		write_rate(16'h8000);
		hold_sender = 0;
		queue_random(250);
		wait_drained();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (timed_out) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
rtl/core/cfta_pkg.sv
rtl/core/correlation_filter_train_and_apply_core.sv
sim/correlation_filter_train_and_apply_core_tb.sv
